// ----- rtl/core/rgbc_pkg.sv -----
// shared types, codes and channel helpers for the pixel converter
package rgbc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_FORMAT       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERSION_DIRECTION = 1'b1;

    localparam logic [2:0] SF_BGRA32   = 3'd0;
    localparam logic [2:0] SF_RGB565   = 3'd1;
    localparam logic [2:0] SF_ARGB1555 = 3'd2;
    localparam logic [2:0] SF_ARGB4444 = 3'd3;

    // decoded pixel layout for one item
    typedef enum logic [2:0] {
        K_PASS  = 3'd0,
        K_565   = 3'd1,
        K_1555  = 3'd2,
        K_4444  = 3'd3,
        K_ERR   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  pack;
    } t_ctl;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

    // times 17 is the nibble repeated
    function automatic logic [7:0] widen4(input logic [3:0] v);
        widen4 = {v, v};
    endfunction

endpackage

// ----- rtl/core/rgb16_bgra32_pixel_converter.sv -----
// top level: 16-bit surface pixel to and from 32-bit bgra, three-stage pipeline
// o_done marks each result once its item has passed all three register stages
// throughput: one item per cycle, busy never rises; the pipeline is three
//   register stages (input capture, lane split, widen or pack) with no feedback
// reset: synchronous active-low; clears the valid bits and both config registers
// the receiver cannot stall: each result is shown for exactly one cycle
module rgb16_bgra32_pixel_converter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [31:0]                    i_pixel_in,
    input  logic                           i_cfg_we,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_done,
    output logic [31:0]                    o_pixel_out,
    output logic                           o_format_error
);
    import rgbc_pkg::*;

    // decoded mode from the config registers
    t_ctl        cfg_ctl;

    // stage one: input capture
    logic        r_s1_valid;
    t_ctl        r_s1_ctl;
    logic [31:0] r_s1_pixel;

    // stage two outputs
    logic        s2_valid;
    t_ctl        s2_ctl;
    logic [31:0] s2_lanes;

    logic        accept;

    // nothing downstream can push back, so the pipe never refuses an item
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    rgbc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (cfg_ctl)
    );

    // mode is sampled with the item, so it rides the pipe with its pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl   <= cfg_ctl;
            r_s1_pixel <= i_pixel_in;
        end
    end

    // split the packed fields into byte lanes
    rgbc_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_ctl   (r_s1_ctl),
        .i_pixel (r_s1_pixel),
        .o_valid (s2_valid),
        .o_ctl   (s2_ctl),
        .o_lanes (s2_lanes)
    );

    // pass bgra32 through, widen for unpack, truncate for pack, zero with error flag when unsupported
    rgbc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_ctl   (s2_ctl),
        .i_lanes (s2_lanes),
        .o_valid (o_done),
        .o_pixel (o_pixel_out),
        .o_error (o_format_error)
    );

endmodule

// ----- rtl/core/rgbc_cfg.sv -----
// configuration registers and format decode
module rgbc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rgbc_pkg::t_ctl                 o_ctl
);
    import rgbc_pkg::*;

    logic [2:0] r_surface_format;
    logic       r_conversion_direction;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_format       <= SF_BGRA32;
            r_conversion_direction <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SURFACE_FORMAT:       r_surface_format       <= i_cfg_data[2:0];
                REG_CONVERSION_DIRECTION: r_conversion_direction <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_ctl.pack = r_conversion_direction;
        case (r_surface_format)
            SF_BGRA32:   o_ctl.kind = K_PASS;
            SF_RGB565:   o_ctl.kind = K_565;
            SF_ARGB1555: o_ctl.kind = K_1555;
            SF_ARGB4444: o_ctl.kind = K_4444;
            default:     o_ctl.kind = K_ERR;
        endcase
    end

endmodule

// ----- rtl/core/rgbc_split.sv -----
// second stage: when unpacking, pulls the channel fields apart into one byte lane each; other items pass unchanged
module rgbc_split (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rgbc_pkg::t_ctl i_ctl,
    input  logic [31:0]    i_pixel,
    output logic           o_valid,
    output rgbc_pkg::t_ctl o_ctl,
    output logic [31:0]    o_lanes
);
    import rgbc_pkg::*;

    logic           r_valid;
    t_ctl           r_ctl;
    logic [31:0]    r_lanes;
    logic [31:0]    n_lanes;
    logic [15:0]    w;

    assign w = i_pixel[15:0];

    // unpacked lanes are a|r|g|b, each field low-aligned in its byte
    always_comb begin
        n_lanes = i_pixel;
        if (!i_ctl.pack) begin
            case (i_ctl.kind)
                K_565:   n_lanes = {8'h00, 3'b0, w[15:11], 2'b0, w[10:5], 3'b0, w[4:0]};
                K_1555:  n_lanes = {7'b0, w[15], 3'b0, w[14:10], 3'b0, w[9:5], 3'b0, w[4:0]};
                K_4444:  n_lanes = {4'b0, w[15:12], 4'b0, w[11:8], 4'b0, w[7:4], 4'b0, w[3:0]};
                default: n_lanes = i_pixel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_ctl   <= i_ctl;
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_lanes = r_lanes;

endmodule

// ----- rtl/core/rgbc_merge.sv -----
// third stage: widens or truncates each lane and builds the output word, or passes bgra32 through
module rgbc_merge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rgbc_pkg::t_ctl i_ctl,
    input  logic [31:0]    i_lanes,
    output logic           o_valid,
    output logic [31:0]    o_pixel,
    output logic           o_error
);
    import rgbc_pkg::*;

    logic        r_valid;
    logic [31:0] r_pixel;
    logic        r_error;
    logic [31:0] n_pixel;
    logic        n_error;
    logic [7:0]  la, lr, lg, lb;

    assign la = i_lanes[31:24];
    assign lr = i_lanes[23:16];
    assign lg = i_lanes[15:8];
    assign lb = i_lanes[7:0];

    always_comb begin
        n_error = 1'b0;
        n_pixel = i_lanes;
        case (i_ctl.kind)
            K_PASS: n_pixel = i_lanes;
            K_565: begin
                if (i_ctl.pack)
                    n_pixel = {16'h0000, lr[7:3], lg[7:2], lb[7:3]};
                else
                    n_pixel = {8'hff, widen5(lr[4:0]), widen6(lg[5:0]), widen5(lb[4:0])};
            end
            K_1555: begin
                if (i_ctl.pack)
                    n_pixel = {16'h0000, la[7], lr[7:3], lg[7:3], lb[7:3]};
                else
                    n_pixel = {{8{la[0]}}, widen5(lr[4:0]), widen5(lg[4:0]),
                               widen5(lb[4:0])};
            end
            K_4444: begin
                if (i_ctl.pack)
                    n_pixel = {16'h0000, la[7:4], lr[7:4], lg[7:4], lb[7:4]};
                else
                    n_pixel = {widen4(la[3:0]), widen4(lr[3:0]), widen4(lg[3:0]),
                               widen4(lb[3:0])};
            end
            default: begin
                n_pixel = 32'h0000_0000;
                n_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_pixel <= n_pixel;
            r_error <= n_error;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_error = r_error;

endmodule
